@@ sv/fcb_pkg.sv @@
// Package for the two-channel 243-tap comb band-stop FIR filter.
// Holds the controller state type, the command and status structs and the coefficient table.
// Depends on nothing; fcb_ctrl, fcb_dpath and the top level import it.
`default_nettype none

package fcb_pkg;

   localparam int TAPS   = 243;
   localparam int IDX_W  = 8;
   localparam int DATA_W = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 40;
   localparam int FRAC_W = 15;
   localparam int Q_W    = ACC_W - FRAC_W;
   localparam int SUM_W  = Q_W + 1;
   localparam logic [DATA_W-1:0] MID_RESET = 16'd32768;
   localparam logic [DATA_W-1:0] SAT_MAX   = 16'd65535;
   localparam logic [FRAC_W-1:0] ROUND_BIAS = 15'd32767;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_EMIT
   } fcb_state_type;

   typedef struct packed {
      logic clr_en;
      logic load;
      logic issue;
      logic scale;
      logic emit;
   } fcb_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic tap_last;
      logic pipe_busy;
      logic out_free;
   } fcb_stat_type;

   // Coefficients in Q15; the entries past the last tap are zero.
   localparam logic signed [DATA_W-1:0] COEF_ROM [0:255] = '{
      -16'sd1, -16'sd1, -16'sd2, -16'sd3, -16'sd2, -16'sd1, 16'sd0, 16'sd2, 16'sd4, 16'sd7,
      16'sd7, 16'sd5, 16'sd5, 16'sd4, 16'sd1, -16'sd3, 16'sd0, 16'sd5, 16'sd7, 16'sd9,
      16'sd17, 16'sd24, 16'sd21, 16'sd13, 16'sd13, 16'sd11, 16'sd0, -16'sd9, 16'sd3, 16'sd20,
      16'sd27, 16'sd37, 16'sd64, 16'sd81, 16'sd61, 16'sd28, 16'sd3, -16'sd41, -16'sd124,
      -16'sd199, -16'sd228, -16'sd244,
      -16'sd269, -16'sd251, -16'sd160, -16'sd64, -16'sd10, 16'sd55, 16'sd155, 16'sd204,
      16'sd159, 16'sd114, 16'sd118, 16'sd85, -16'sd13, -16'sd49, 16'sd25, 16'sd80, 16'sd61,
      16'sd103, 16'sd233, 16'sd274, 16'sd174, 16'sd119, 16'sd160, 16'sd109, -16'sd53,
      -16'sd80, 16'sd76, 16'sd160, 16'sd128, 16'sd238, 16'sd480, 16'sd512, 16'sd292,
      16'sd151, 16'sd102, -16'sd209, -16'sd734, -16'sd1007, -16'sd997, -16'sd1124, -16'sd1326,
      -16'sd1106, -16'sd550, -16'sd251, -16'sd183, 16'sd197, 16'sd736, 16'sd750, 16'sd383,
      16'sd375, 16'sd590, 16'sd288, -16'sd262, -16'sd162, 16'sd326, 16'sd242, -16'sd113,
      16'sd269, 16'sd946, 16'sd721, 16'sd63, 16'sd281,
      16'sd821, 16'sd266, -16'sd637, -16'sd187, 16'sd785, 16'sd348, -16'sd498, 16'sd468,
      16'sd1910, 16'sd989, -16'sd749, 16'sd267, 16'sd2066, -16'sd356, -16'sd4516, -16'sd1675,
      16'sd8603, 16'sd14615, 16'sd8603, -16'sd1675, -16'sd4516, -16'sd356, 16'sd2066, 16'sd267,
      -16'sd749, 16'sd989, 16'sd1910, 16'sd468,
      -16'sd498, 16'sd348, 16'sd785, -16'sd187, -16'sd637, 16'sd266, 16'sd821, 16'sd281,
      16'sd63, 16'sd721, 16'sd946, 16'sd269, -16'sd113, 16'sd242, 16'sd326, -16'sd162,
      -16'sd262, 16'sd288, 16'sd590, 16'sd375, 16'sd383, 16'sd750, 16'sd736, 16'sd197,
      -16'sd183, -16'sd251, -16'sd550, -16'sd1106, -16'sd1326, -16'sd1124,
      -16'sd997, -16'sd1007, -16'sd734, -16'sd209, 16'sd102, 16'sd151, 16'sd292, 16'sd512,
      16'sd480, 16'sd238, 16'sd128, 16'sd160, 16'sd76, -16'sd80, -16'sd53, 16'sd109, 16'sd160,
      16'sd119, 16'sd174, 16'sd274, 16'sd233, 16'sd103, 16'sd61, 16'sd80, 16'sd25, -16'sd49,
      -16'sd13, 16'sd85, 16'sd118, 16'sd114, 16'sd159, 16'sd204, 16'sd155,
      16'sd55, -16'sd10, -16'sd64, -16'sd160, -16'sd251, -16'sd269, -16'sd244, -16'sd228,
      -16'sd199, -16'sd124, -16'sd41, 16'sd3, 16'sd28, 16'sd61, 16'sd81, 16'sd64, 16'sd37,
      16'sd27, 16'sd20, 16'sd3, -16'sd9, 16'sd0, 16'sd11, 16'sd13, 16'sd13, 16'sd21, 16'sd24,
      16'sd17, 16'sd9, 16'sd7, 16'sd5, 16'sd0, -16'sd3, 16'sd1, 16'sd4, 16'sd5, 16'sd5, 16'sd7,
      16'sd7, 16'sd4,
      16'sd2, 16'sd0, -16'sd1, -16'sd2, -16'sd3, -16'sd2, -16'sd1, -16'sd1,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0
   };

endpackage

`default_nettype wire

@@ sv/fcb_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module fcb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/fcb_ctrl.sv @@
// Controller state machine of the comb band-stop FIR filter.
// Depends on fcb_pkg; drives the datapath through fcb_cmd_type and reads fcb_stat_type.
`default_nettype none

module fcb_ctrl
   import fcb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire fcb_stat_type stat,
   output fcb_cmd_type       cmd
);

   fcb_state_type state_ff;
   fcb_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (stat.tap_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_en = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN:   cmd.issue = 1'b1;
         ST_DRAIN: cmd = '0;
         ST_SCALE: cmd.scale = 1'b1;
         ST_EMIT:  cmd.emit = stat.out_free;
         default:  cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && stat.tap_last) |=> state_ff == ST_DRAIN)
      else $error("tap sweep did not end after the last tap");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> !stat.pipe_busy)
      else $error("scaling started before the accumulation finished");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during the clearing pass");

endmodule

`default_nettype wire

@@ sv/fcb_dpath.sv @@
// Datapath of the comb band-stop FIR filter: offset register, write pointers, delay RAM,
// multiply-accumulate pipeline, scaling, saturation and the result register.
// Depends on fcb_pkg and fcb_ram.
`default_nettype none

module fcb_dpath
   import fcb_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fcb_cmd_type       cmd,
   output fcb_stat_type           stat,
   input  wire logic [DATA_W-1:0] req_sample,
   input  wire logic              req_channel,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [DATA_W-1:0] rsp_filtered,
   input  wire logic              csr_wr_en,
   input  wire logic [DATA_W-1:0] csr_wr_data
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW    = CH_W + IDX_W;
   localparam int DEPTH = 1 << AW;

   logic [DATA_W-1:0]       mid_ff;
   logic [IDX_W-1:0]        ptr_ff [CHANNELS];
   logic [CH_W-1:0]         ch_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [IDX_W-1:0]        tap_ff;
   logic [IDX_W-1:0]        cidx_ff;
   logic                    v1_ff;
   logic                    v2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [Q_W-1:0]   q_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic [DATA_W-1:0]       out_ff;
   logic                    out_valid_ff;

   logic [CH_W-1:0]         ch_sel;
   logic [IDX_W-1:0]        ptr_cur;
   logic [IDX_W-1:0]        ptr_next;
   logic [IDX_W-1:0]        rd_idx_in;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [DATA_W-1:0]       ram_wr_data;
   logic [DATA_W-1:0]       ram_rd_data;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0] acc_adj;
   logic signed [SUM_W-1:0] sum;
   logic [DATA_W-1:0]       out_in;

   assign ch_sel   = (CHANNELS > 1) ? CH_W'(req_channel) : '0;
   assign ptr_cur  = ptr_ff[ch_sel];
   assign ptr_next = (ptr_cur == IDX_W'(TAPS - 1)) ? '0 : ptr_cur + 1'b1;
   assign rd_idx_in = (rd_idx_ff == IDX_W'(TAPS - 1)) ? '0 : rd_idx_ff + 1'b1;

   always_comb begin
      ram_wr_en   = cmd.clr_en | cmd.load;
      ram_wr_addr = clr_cnt_ff;
      ram_wr_data = '0;
      if (cmd.load) begin
         ram_wr_addr = {ch_sel, ptr_cur};
         ram_wr_data = req_sample - mid_ff;
      end
   end

   fcb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.issue),
      .rd_addr ({ch_ff, rd_idx_ff}),
      .rd_data (ram_rd_data)
   );

   assign prod_in = COEF_ROM[cidx_ff] * $signed(ram_rd_data);
   assign acc_adj = acc_ff[ACC_W-1] ? acc_ff + ACC_W'(ROUND_BIAS) : acc_ff;
   assign sum     = $signed({q_ff[Q_W-1], q_ff}) + $signed({{(SUM_W-DATA_W){1'b0}}, mid_ff});

   always_comb begin
      priority if (sum[SUM_W-1]) begin
         out_in = '0;
      end else if (|sum[SUM_W-2:DATA_W]) begin
         out_in = SAT_MAX;
      end else begin
         out_in = sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= MID_RESET;
         clr_cnt_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            ptr_ff[c] <= '0;
         end
      end else begin
         if (csr_wr_en) mid_ff <= csr_wr_data;
         if (cmd.clr_en) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.load) ptr_ff[ch_sel] <= ptr_next;
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff     <= ch_sel;
         rd_idx_ff <= ptr_next;
         tap_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         if (cmd.issue) begin
            rd_idx_ff <= rd_idx_in;
            tap_ff    <= tap_ff + 1'b1;
         end
         if (v2_ff) acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
      cidx_ff <= tap_ff;
      if (v1_ff) prod_ff <= prod_in;
      if (cmd.scale) q_ff <= acc_adj[ACC_W-1:FRAC_W];
      if (cmd.emit) out_ff <= out_in;
   end

   assign stat.clr_last  = &clr_cnt_ff;
   assign stat.tap_last  = (tap_ff == IDX_W'(TAPS - 1));
   assign stat.pipe_busy = v1_ff | v2_ff;
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rd_idx_ff == ptr_ff[ch_ff])
      else $error("read index does not start at the oldest sample");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      cmd.scale |-> (!v1_ff && !v2_ff && !cmd.issue))
      else $error("scaling while products are still in flight");

   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (tap_ff < IDX_W'(TAPS) && rd_idx_ff < IDX_W'(TAPS)))
      else $error("tap or read index out of range");

endmodule

`default_nettype wire

@@ sv/fir_comb_bandstop_two_channel_core.sv @@
// Top level of the two-channel 243-tap comb band-stop FIR filter.
// Depends on fcb_pkg, fcb_ctrl and fcb_dpath (which holds fcb_ram).
//
//   Channel    Handshake               Payload
//   request    req_valid / req_ready   req_sample[15:0], req_channel
//   response   rsp_valid / rsp_ready   rsp_filtered[15:0]
//   csr        csr_wr_en               csr_wr_data[15:0] (midpoint offset)
//
// A request is taken in the idle state, which also stores its sample. Its result is registered
// after a sweep of one tap per cycle through the single multiply-accumulate unit, a drain of the
// pipeline, a scaling step and a saturating step; no new request is taken until then.
// After reset the delay RAM is cleared, all 512 addresses (2^(channel index bits + 8), at least
// one index bit), before the first request is taken. A held result does not stop the next
// request from being accepted; it only holds the final write of the next result until taken.
`default_nettype none

module fir_comb_bandstop_two_channel_core
   import fcb_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [DATA_W-1:0] req_sample,
   input  wire logic              req_channel,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [DATA_W-1:0] rsp_filtered,
   input  wire logic              csr_wr_en,
   input  wire logic [DATA_W-1:0] csr_wr_data
);

   fcb_cmd_type  cmd;
   fcb_stat_type stat;

   fcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fcb_dpath #(
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_sample   (req_sample),
      .req_channel  (req_channel),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

endmodule

`default_nettype wire
